// ===== design/rie_pkg.sv =====
// Package: request and response types, mnemonic codes and the encoding table.
package rie_pkg;

  typedef enum logic [2:0] {
    FMT_R  = 3'd0,
    FMT_I  = 3'd1,
    FMT_S  = 3'd2,
    FMT_SB = 3'd3,
    FMT_U  = 3'd4,
    FMT_UJ = 3'd5
  } fmt_e;

  typedef enum logic [4:0] {
    MN_ADD     = 5'd0,
    MN_SUB     = 5'd1,
    MN_AND     = 5'd2,
    MN_OR      = 5'd3,
    MN_SLL     = 5'd4,
    MN_SLT     = 5'd5,
    MN_SRA     = 5'd6,
    MN_SRL     = 5'd7,
    MN_XOR     = 5'd8,
    MN_MUL     = 5'd9,
    MN_DIV     = 5'd10,
    MN_REM     = 5'd11,
    MN_ADDI    = 5'd12,
    MN_ANDI    = 5'd13,
    MN_ORI     = 5'd14,
    MN_LB      = 5'd15,
    MN_LH      = 5'd16,
    MN_LW      = 5'd17,
    MN_LD      = 5'd18,
    MN_JALR    = 5'd19,
    MN_SB      = 5'd20,
    MN_SH      = 5'd21,
    MN_SW      = 5'd22,
    MN_SD      = 5'd23,
    MN_BEQ     = 5'd24,
    MN_BNE     = 5'd25,
    MN_BLT     = 5'd26,
    MN_BGE     = 5'd27,
    MN_LUI     = 5'd28,
    MN_AUIPC   = 5'd29,
    MN_JAL     = 5'd30,
    MN_UNKNOWN = 5'd31
  } mnem_e;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [4:0]  rd_index;
    logic [4:0]  rs1_index;
    logic [4:0]  rs2_index;
    logic [31:0] imm_value;
    logic        use_label;
    logic [31:0] label_address;
    logic [31:0] instr_address;
  } req_t;

  typedef struct packed {
    logic [31:0] machine_word;
    logic        bad_mnemonic;
  } rsp_t;

  typedef struct packed {
    logic       known;
    fmt_e       fmt;
    logic [6:0] major;
    logic [2:0] f3;
    logic [6:0] f7;
  } entry_t;

  function automatic entry_t mk(fmt_e fmt, logic [6:0] major, logic [2:0] f3,
                                logic [6:0] f7);
    entry_t e;
    e.known = 1'b1;
    e.fmt   = fmt;
    e.major = major;
    e.f3    = f3;
    e.f7    = f7;
    return e;
  endfunction

  function automatic entry_t lookup(logic [4:0] code);
    entry_t e;
    e = '{known: 1'b0, fmt: FMT_R, major: 7'h00, f3: 3'd0, f7: 7'h00};
    unique case (mnem_e'(code))
      MN_ADD:   e = mk(FMT_R, OP_REG, 3'd0, F7_BASE);
      MN_SUB:   e = mk(FMT_R, OP_REG, 3'd0, F7_ALT);
      MN_AND:   e = mk(FMT_R, OP_REG, 3'd7, F7_BASE);
      MN_OR:    e = mk(FMT_R, OP_REG, 3'd6, F7_BASE);
      MN_SLL:   e = mk(FMT_R, OP_REG, 3'd1, F7_BASE);
      MN_SLT:   e = mk(FMT_R, OP_REG, 3'd2, F7_BASE);
      MN_SRA:   e = mk(FMT_R, OP_REG, 3'd5, F7_ALT);
      MN_SRL:   e = mk(FMT_R, OP_REG, 3'd5, F7_BASE);
      MN_XOR:   e = mk(FMT_R, OP_REG, 3'd4, F7_BASE);
      MN_MUL:   e = mk(FMT_R, OP_REG, 3'd0, F7_MULDIV);
      MN_DIV:   e = mk(FMT_R, OP_REG, 3'd4, F7_MULDIV);
      MN_REM:   e = mk(FMT_R, OP_REG, 3'd6, F7_MULDIV);
      MN_ADDI:  e = mk(FMT_I, OP_IMM, 3'd0, F7_BASE);
      MN_ANDI:  e = mk(FMT_I, OP_IMM, 3'd7, F7_BASE);
      MN_ORI:   e = mk(FMT_I, OP_IMM, 3'd6, F7_BASE);
      MN_LB:    e = mk(FMT_I, OP_LOAD, 3'd0, F7_BASE);
      MN_LH:    e = mk(FMT_I, OP_LOAD, 3'd1, F7_BASE);
      MN_LW:    e = mk(FMT_I, OP_LOAD, 3'd2, F7_BASE);
      MN_LD:    e = mk(FMT_I, OP_LOAD, 3'd3, F7_BASE);
      MN_JALR:  e = mk(FMT_I, OP_JALR, 3'd0, F7_BASE);
      MN_SB:    e = mk(FMT_S, OP_STORE, 3'd0, F7_BASE);
      MN_SH:    e = mk(FMT_S, OP_STORE, 3'd1, F7_BASE);
      MN_SW:    e = mk(FMT_S, OP_STORE, 3'd2, F7_BASE);
      MN_SD:    e = mk(FMT_S, OP_STORE, 3'd3, F7_BASE);
      MN_BEQ:   e = mk(FMT_SB, OP_BRANCH, 3'd0, F7_BASE);
      MN_BNE:   e = mk(FMT_SB, OP_BRANCH, 3'd1, F7_BASE);
      MN_BLT:   e = mk(FMT_SB, OP_BRANCH, 3'd4, F7_BASE);
      MN_BGE:   e = mk(FMT_SB, OP_BRANCH, 3'd5, F7_BASE);
      MN_LUI:   e = mk(FMT_U, OP_LUI, 3'd0, F7_BASE);
      MN_AUIPC: e = mk(FMT_U, OP_AUIPC, 3'd0, F7_BASE);
      MN_JAL:   e = mk(FMT_UJ, OP_JAL, 3'd0, F7_BASE);
      default:  e.known = 1'b0;
    endcase
    return e;
  endfunction

endpackage

// ===== design/rie_if.sv =====
// Interfaces: request and response channels with valid/ready handshake.
interface rie_req_if;
  logic           valid;
  logic           ready;
  rie_pkg::req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rie_rsp_if;
  logic           valid;
  logic           ready;
  rie_pkg::rsp_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/rie_stage.sv =====
// Pipeline register stage with valid/ready flow control.
module rie_stage #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q;
  logic valid_d;
  T     data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/rie_encode.sv =====
// Encoder: table lookup, immediate selection and bit placement per format.
module rie_encode (
  input  rie_pkg::req_t req_i,
  output rie_pkg::rsp_t rsp_o
);

  rie_pkg::entry_t ent;
  logic [31:0]     imm;
  logic [31:0]     word;

  assign ent = rie_pkg::lookup(req_i.opcode);

  always_comb begin
    imm = req_i.imm_value;
    if (req_i.use_label) begin
      if (ent.fmt == rie_pkg::FMT_SB || ent.fmt == rie_pkg::FMT_UJ) begin
        imm = req_i.label_address - req_i.instr_address;
      end else if (ent.fmt == rie_pkg::FMT_I || ent.fmt == rie_pkg::FMT_U) begin
        imm = req_i.label_address;
      end
    end
  end

  always_comb begin
    unique case (ent.fmt)
      rie_pkg::FMT_R:
        word = {ent.f7, req_i.rs2_index, req_i.rs1_index, ent.f3, req_i.rd_index,
                ent.major};
      rie_pkg::FMT_I:
        word = {imm[11:0], req_i.rs1_index, ent.f3, req_i.rd_index, ent.major};
      rie_pkg::FMT_S:
        word = {imm[11:5], req_i.rs2_index, req_i.rs1_index, ent.f3, imm[4:0],
                ent.major};
      rie_pkg::FMT_SB:
        word = {imm[12], imm[10:5], req_i.rs2_index, req_i.rs1_index, ent.f3,
                imm[4:1], imm[11], ent.major};
      rie_pkg::FMT_U:
        word = {imm[19:0], req_i.rd_index, ent.major};
      default:
        word = {imm[20], imm[10:1], imm[11], imm[19:12], req_i.rd_index, ent.major};
    endcase
  end

  assign rsp_o.machine_word = ent.known ? word : 32'h0000_0000;
  assign rsp_o.bad_mnemonic = !ent.known;

endmodule

// ===== design/riscv_instruction_encoder_unit.sv =====
// Top level: RISC-V integer and multiply/divide instruction encoder, input register, encoder, result register.
//
// Usage: each request on req_i carries one tokenised instruction (mnemonic
// index, register numbers, immediate, label flag and addresses). For every
// accepted request exactly one response appears on rsp_o holding the 32-bit
// machine word and a bad-mnemonic flag; an unknown index gives a zero word.
// Requests are accepted when valid and ready are both high at a clock edge.
//
// The response passes through the input register and then the result register,
// with the table lookup and bit placement in between. Throughput is one
// request per cycle while the receiver takes every response.
//
// When the receiver stalls, the result register holds its response and the
// input register fills; req_i.ready falls only once both hold a request.
// Reset clears both valid flags; no request is in flight afterwards.
module riscv_instruction_encoder_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  rie_req_if.sink        req_i,
  rie_rsp_if.source      rsp_o
);

  logic          in_valid;
  logic          out_ready;
  rie_pkg::req_t in_data;
  rie_pkg::rsp_t enc_data;

  rie_stage #(.T(rie_pkg::req_t)) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .data_i  (req_i.payload),
    .valid_o (in_valid),
    .ready_i (out_ready),
    .data_o  (in_data)
  );

  rie_encode u_encode (
    .req_i (in_data),
    .rsp_o (enc_data)
  );

  rie_stage #(.T(rie_pkg::rsp_t)) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (out_ready),
    .data_i  (enc_data),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .data_o  (rsp_o.payload)
  );

  a_err_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.payload.bad_mnemonic |-> rsp_o.payload.machine_word == 32'h0)
    else $error("bad mnemonic response with non-zero word");

  a_word_low_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.payload.bad_mnemonic |-> rsp_o.payload.machine_word[1:0] == 2'b11)
    else $error("encoded word lacks 32-bit opcode marker");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && out_ready |=> rsp_o.valid)
    else $error("request lost between input and result registers");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid |-> req_i.ready)
    else $error("empty input register refuses request");

endmodule
